@@ hdl/ple_pkg.sv @@
// ple_pkg: shared types and constants for the positional list engine
// holds beat payload structs, cell command struct, operation and status codes
// no dependencies
package ple_pkg;

    // list capacity and widths; the index width is derived from the capacity
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;

    typedef logic [1:0]              t_kind;
    typedef logic [1:0]              t_status;
    typedef logic [POS_W-1:0]        t_pos;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic signed [VAL_W-1:0] t_value;

    // operation codes
    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_REMOVE = 2'd1;
    localparam t_kind KIND_READ   = 2'd2;

    // status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_RANGE = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

    typedef struct packed {
        t_kind  kind;
        t_pos   position;
        t_value value;
    } t_in_item;

    typedef struct packed {
        t_value  data_out;
        t_status status;
        t_count  count_out;
    } t_out_item;

    // broadcast command to every cell of the row
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_pos   pos;
        t_value value;
    } t_cell_cmd;

endpackage

@@ hdl/ple_cell.sv @@
// ple_cell: one storage cell of the list row
// shifts toward or away from its neighbors on insert and remove
// depends on ple_pkg
module ple_cell (
    input  logic               i_clk,
    input  ple_pkg::t_cell_cmd i_cmd,
    input  ple_pkg::t_idx      i_index,
    input  ple_pkg::t_value    i_left,
    input  ple_pkg::t_value    i_right,
    output ple_pkg::t_value    o_data
);
    import ple_pkg::*;

    t_value r_data;
    t_value n_data;
    t_pos   w_index;

    assign w_index = t_pos'(i_index);

    // next value: own write, shift from left neighbor, or from right neighbor
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (w_index == i_cmd.pos) begin
                n_data = i_cmd.value;
            end else if (w_index > i_cmd.pos) begin
                n_data = i_left;
            end
        end else if (i_cmd.rem) begin
            if (w_index >= i_cmd.pos) begin
                n_data = i_right;
            end
        end
    end

    // storage, not cleared at reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ hdl/positional_list_engine_core.sv @@
// positional_list_engine_core: bounded ordered list with insert, remove and read by position
// result beat registered, out the cycle after its input beat is accepted; throughput
// one beat per cycle unless stalled, set by the cell row, which shifts every entry at once
// input is stalled only while a result beat waits and the output is stalled
// synchronous active-low reset clears the count and the output valid; cell contents are not
// cleared and are only read after written; depends on ple_pkg and ple_cell
module positional_list_engine_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ple_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output ple_pkg::t_out_item o_data
);
    import ple_pkg::*;

    logic      w_accept;
    logic      w_ins;
    logic      w_ok;
    t_cell_cmd w_cmd;
    t_value    w_cell [DEPTH];
    t_value    w_read;
    t_out_item w_result;

    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    t_count    r_count;
    t_count    n_count;

    // handshake
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_ins    = (i_data.kind == KIND_INSERT);

    // selected entry for read and remove
    assign w_read = w_cell[i_data.position[IDX_W-1:0]];

    // status, data and new count
    always_comb begin
        w_result.data_out  = '0;
        w_result.status    = ST_OK;
        w_result.count_out = r_count;
        if (w_ins) begin
            if (i_data.position > r_count) begin
                w_result.status = ST_RANGE;
            end else if (r_count >= CNT_W'(DEPTH)) begin
                w_result.status = ST_FULL;
            end else begin
                w_result.count_out = r_count + 1'b1;
            end
        end else begin
            if (r_count == '0) begin
                w_result.status = ST_EMPTY;
            end else if (i_data.position >= r_count) begin
                w_result.status = ST_RANGE;
            end else begin
                w_result.data_out = w_read;
                if (i_data.kind == KIND_REMOVE) begin
                    w_result.count_out = r_count - 1'b1;
                end
            end
        end
    end

    assign w_ok = (w_result.status == ST_OK);

    // command broadcast to the cell row
    assign w_cmd.ins   = w_accept & w_ok & w_ins;
    assign w_cmd.rem   = w_accept & w_ok & (i_data.kind == KIND_REMOVE);
    assign w_cmd.pos   = i_data.position;
    assign w_cmd.value = i_data.value;

    // row of cells, each linked to its neighbors; the end cells see zero beyond the row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value w_left;
        t_value w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    // next count and output beat
    always_comb begin
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_count     = w_result.count_out;
            n_out       = w_result;
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef NO_ASSERTIONS
    // count stays within capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above capacity");

    // every accepted beat yields a result beat next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("result beat missing");

    // a waiting result reports the current count
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.count_out == r_count))
        else $error("result count differs from list count");

    // a successful insert grows the list by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow list");
`endif

endmodule
